// File: src/lav_pkg.sv
package lav_pkg;

   // Width of every coordinate and matrix entry on the channels.
   localparam int COORD_W = 32;
   localparam int ROW_W   = 2;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [ROW_W-1:0]          row_type;

   // Row numbers of the emitted matrix.
   localparam row_type ROW_SIDE = 2'd0;
   localparam row_type ROW_UP   = 2'd1;
   localparam row_type ROW_BACK = 2'd2;
   localparam row_type ROW_LAST = 2'd3;

   // Cyclic neighbors of a vector component, used by the cross products.
   localparam int NXT [3] = '{1, 2, 0};
   localparam int PRV [3] = '{2, 0, 1};

endpackage

// File: src/lav_req_if.sv
interface lav_req_if;
   import lav_pkg::*;

   logic      valid;
   logic      ready;
   coord_type eye_x;
   coord_type eye_y;
   coord_type eye_z;
   coord_type target_x;
   coord_type target_y;
   coord_type target_z;
   coord_type upvec_x;
   coord_type upvec_y;
   coord_type upvec_z;

   modport source (
      output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
      output upvec_x, upvec_y, upvec_z,
      input  ready
   );
   modport sink (
      input  valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
      input  upvec_x, upvec_y, upvec_z,
      output ready
   );
endinterface

// File: src/lav_rsp_if.sv
interface lav_rsp_if;
   import lav_pkg::*;

   logic      valid;
   logic      ready;
   row_type   row_index;
   coord_type entry_0;
   coord_type entry_1;
   coord_type entry_2;
   coord_type entry_3;
   logic      last_row;

   modport source (
      output valid, row_index, entry_0, entry_1, entry_2, entry_3, last_row,
      input  ready
   );
   modport sink (
      input  valid, row_index, entry_0, entry_1, entry_2, entry_3, last_row,
      output ready
   );
endinterface

// File: src/lav_unit.sv
// Pipelined vector normalizer: scale to a fixed exponent, square root one
// bit per stage, then one quotient bit per stage for all three components.
module lav_unit #(
   parameter int IN_W      = 33,
   parameter int FRAC_BITS = 16,
   parameter int SB_W      = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic signed [IN_W-1:0]      in_vec [3],
   input  logic [SB_W-1:0]             in_sb,
   output logic                        out_valid,
   output logic signed [FRAC_BITS+1:0] out_vec [3],
   output logic [SB_W-1:0]             out_sb
);
   localparam int NORM_W   = 30;
   localparam int SUM_W    = 2 * NORM_W + 2;
   localparam int LEN_W    = NORM_W + 1;
   localparam int SQ_STEPS = LEN_W;
   localparam int GRP      = (IN_W + 7) / 8;
   localparam int BITS_W   = $clog2(IN_W + 1);
   localparam int QUO_W    = FRAC_BITS + 1;
   localparam int NUM_W    = NORM_W + FRAC_BITS + 1;
   localparam int OUT_W    = FRAC_BITS + 2;
   localparam int CY_W     = SB_W + 3 + 3 * NORM_W;
   localparam int ST_SQ    = 5;
   localparam int ST_DV    = ST_SQ + SQ_STEPS + 1;
   localparam int ST_OUT   = ST_DV + QUO_W + 1;
   localparam int N_ST     = ST_OUT + 1;

   logic [N_ST-1:0]         v_ff, v_in;
   logic [CY_W-1:0]         cy_ff [N_ST], cy_in [N_ST];
   logic [IN_W-1:0]         mag_ff [3][3], mag_in [3][3];
   logic [3:0]              glen_ff [GRP], glen_in [GRP];
   logic [BITS_W-1:0]       bits_ff, bits_in;
   logic [2*NORM_W-1:0]     sq_ff [3], sq_in [3];
   logic [SUM_W-1:0]        sn_ff [SQ_STEPS+1], sn_in [SQ_STEPS+1];
   logic [SUM_W-1:0]        sr_ff [SQ_STEPS+1], sr_in [SQ_STEPS+1];
   logic [LEN_W-1:0]        dvs_ff [QUO_W+1], dvs_in [QUO_W+1];
   logic [NUM_W-1:0]        rem_ff [QUO_W+1][3], rem_in [QUO_W+1][3];
   logic [QUO_W-1:0]        quo_ff [QUO_W+1][3], quo_in [QUO_W+1][3];
   logic signed [OUT_W-1:0] res_ff [3], res_in [3];

   always_comb begin
      logic [IN_W-1:0]        orv;
      logic [GRP*8-1:0]       orx;
      logic [IN_W+NORM_W-1:0] wide;
      logic [SUM_W:0]         trial;
      logic [SUM_W-1:0]       bitv;
      logic [NUM_W-1:0]       dsh;
      logic [LEN_W-1:0]       len;
      logic [2:0]             negs;

      v_in = {v_ff[N_ST-2:0], in_valid};

      // Magnitudes and signs.
      for (int i = 0; i < 3; i++) begin
         negs[i] = in_vec[i][IN_W-1];
         mag_in[0][i] = negs[i] ? IN_W'(-in_vec[i]) : IN_W'(in_vec[i]);
      end
      cy_in[0] = {in_sb, negs, (3*NORM_W)'(0)};
      for (int s = 1; s < N_ST; s++) begin
         cy_in[s] = cy_ff[s-1];
      end

      // Bit length of the largest magnitude, first per byte.
      mag_in[1] = mag_ff[0];
      orv = mag_ff[0][0] | mag_ff[0][1] | mag_ff[0][2];
      orx = (GRP*8)'(orv);
      for (int g = 0; g < GRP; g++) begin
         glen_in[g] = 4'd0;
         for (int b = 0; b < 8; b++) begin
            if (orx[g*8+b]) begin
               glen_in[g] = 4'(b + 1);
            end
         end
      end

      mag_in[2] = mag_ff[1];
      bits_in = '0;
      for (int g = 0; g < GRP; g++) begin
         if (glen_ff[g] != 4'd0) begin
            bits_in = BITS_W'(g * 8) + BITS_W'(glen_ff[g]);
         end
      end

      // Move the leading one of the largest component to bit NORM_W-1.
      for (int i = 0; i < 3; i++) begin
         wide = {mag_ff[2][i], NORM_W'(0)} >> bits_ff;
         cy_in[3][i*NORM_W +: NORM_W] = wide[NORM_W-1:0];
      end

      for (int i = 0; i < 3; i++) begin
         sq_in[i] = (2*NORM_W)'(cy_ff[3][i*NORM_W +: NORM_W])
                  * (2*NORM_W)'(cy_ff[3][i*NORM_W +: NORM_W]);
      end

      sn_in[0] = SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]);
      sr_in[0] = '0;

      // Square root, one result bit per stage.
      for (int j = 0; j < SQ_STEPS; j++) begin
         bitv  = SUM_W'(1) << (2 * (SQ_STEPS - 1 - j));
         trial = {1'b0, sr_ff[j]} + {1'b0, bitv};
         if ({1'b0, sn_ff[j]} >= trial) begin
            sn_in[j+1] = sn_ff[j] - trial[SUM_W-1:0];
            sr_in[j+1] = (sr_ff[j] >> 1) + bitv;
         end else begin
            sn_in[j+1] = sn_ff[j];
            sr_in[j+1] = sr_ff[j] >> 1;
         end
      end

      // A zero vector has zero magnitudes; dividing by one keeps it zero.
      len = sr_ff[SQ_STEPS][LEN_W-1:0];
      dvs_in[0] = (len == '0) ? LEN_W'(1) : len;
      for (int i = 0; i < 3; i++) begin
         rem_in[0][i] = (NUM_W'(cy_ff[ST_DV-1][i*NORM_W +: NORM_W]) << FRAC_BITS)
                      + NUM_W'(len >> 1);
         quo_in[0][i] = '0;
      end

      // Restoring division, one quotient bit per stage.
      for (int k = 0; k < QUO_W; k++) begin
         dvs_in[k+1] = dvs_ff[k];
         dsh = NUM_W'(dvs_ff[k]) << (QUO_W - 1 - k);
         for (int i = 0; i < 3; i++) begin
            quo_in[k+1][i] = quo_ff[k][i];
            if (rem_ff[k][i] >= dsh) begin
               rem_in[k+1][i] = rem_ff[k][i] - dsh;
               quo_in[k+1][i][QUO_W-1-k] = 1'b1;
            end else begin
               rem_in[k+1][i] = rem_ff[k][i];
            end
         end
      end

      for (int i = 0; i < 3; i++) begin
         res_in[i] = cy_ff[ST_OUT-1][3*NORM_W+i] ? -OUT_W'(quo_ff[QUO_W][i])
                                                 :  OUT_W'(quo_ff[QUO_W][i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cy_ff   <= cy_in;
         mag_ff  <= mag_in;
         glen_ff <= glen_in;
         bits_ff <= bits_in;
         sq_ff   <= sq_in;
         sn_ff   <= sn_in;
         sr_ff   <= sr_in;
         dvs_ff  <= dvs_in;
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         res_ff  <= res_in;
      end
   end

   assign out_valid = v_ff[N_ST-1];
   assign out_sb    = cy_ff[N_ST-1][CY_W-1 -: SB_W];
   assign out_vec   = res_ff;

endmodule

// File: src/look_at_view_matrix_core.sv
// Channel   Direction  Handshake      Contents
// req_chan  in         valid / ready  eye, target and up vectors, signed fixed point
// rsp_chan  out        valid / ready  one matrix row per transfer: index, four entries, last flag
//
// Every request yields four response rows; the single response port moves one
// row per cycle while rsp_chan.ready is high, so it limits how often requests
// are taken, though new requests enter while earlier ones are still in flight.
// A request passes through two normalizers of FRAC_BITS+40 stages each plus
// eight stages around them before it reaches the output holder. Reset clears
// only the valid bits and the row counter. When the final stage is full and the
// output holder cannot take it, the whole pipeline holds; nothing is dropped or repeated.
module look_at_view_matrix_core #(
   parameter int FRAC_BITS = 16
) (
   input logic       clock,
   input logic       reset,
   lav_req_if.sink   req_chan,
   lav_rsp_if.source rsp_chan
);
   import lav_pkg::*;

   localparam int UNIT_W = FRAC_BITS + 2;      // normalized component
   localparam int FWD_W  = COORD_W + 1;        // target minus eye
   localparam int PROD_W = UNIT_W + COORD_W;   // unit times coordinate
   localparam int UPP_W  = 2 * UNIT_W;         // unit times unit
   localparam int UPR_W  = FRAC_BITS + 4;      // rounded up' component
   localparam int DOT_W  = FRAC_BITS + 39;     // translation sums
   localparam int SBA_W  = 6 * COORD_W;
   localparam int SBB_W  = 3 * COORD_W + 3 * UNIT_W;

   localparam logic signed [UPP_W-1:0] HALF_UPP = UPP_W'(2 ** (FRAC_BITS - 1));
   localparam logic signed [DOT_W-1:0] HALF_DOT = DOT_W'(2 ** (FRAC_BITS - 1));
   localparam logic signed [DOT_W-1:0] SAT_HI   = DOT_W'(32'sh7fffffff);
   localparam logic signed [DOT_W-1:0] SAT_LO   = DOT_W'(32'sh80000000);
   localparam coord_type               ONE_FX   = coord_type'(2 ** FRAC_BITS);

   function automatic coord_type sat_fx(input logic signed [DOT_W-1:0] v);
      coord_type r;
      if (v > SAT_HI) begin
         r = coord_type'(SAT_HI);
      end else if (v < SAT_LO) begin
         r = coord_type'(SAT_LO);
      end else begin
         r = coord_type'(v);
      end
      return r;
   endfunction

   // Pipeline advance: the final stage is empty or the holder takes it.
   logic adv;
   logic take;

   // Stage 0: forward vector, eye and up ride along as sideband.
   logic                     t0_valid_ff;
   logic signed [FWD_W-1:0]  fwd0_ff [3], fwd0_in [3];
   logic [SBA_W-1:0]         sba_ff, sba_in;

   // Forward normalizer.
   logic                     a_valid;
   logic signed [UNIT_W-1:0] a_vec [3];
   logic [SBA_W-1:0]         a_sb;
   coord_type                eye_a [3];
   coord_type                up_a [3];

   // Stages 1 and 2: side = forward x up.
   logic                     t1_valid_ff, t2_valid_ff;
   logic signed [PROD_W-1:0] p1a_ff [3], p1a_in [3];
   logic signed [PROD_W-1:0] p1b_ff [3], p1b_in [3];
   logic [SBB_W-1:0]         sb1_ff, sb1_in, sb2_ff;
   logic signed [PROD_W-1:0] side2_ff [3], side2_in [3];

   // Side normalizer.
   logic                     b_valid;
   logic signed [UNIT_W-1:0] b_vec [3];
   logic [SBB_W-1:0]         b_sb;
   coord_type                eye_b [3];
   logic signed [UNIT_W-1:0] fwd_b [3];

   // Stages 3 to 7: up', translations, saturation.
   logic                     t3_valid_ff, t4_valid_ff, t5_valid_ff;
   logic                     t6_valid_ff, t7_valid_ff;
   logic signed [UPP_W-1:0]  q3a_ff [3], q3a_in [3];
   logic signed [UPP_W-1:0]  q3b_ff [3], q3b_in [3];
   logic signed [PROD_W-1:0] se3_ff [3], se3_in [3];
   logic signed [PROD_W-1:0] fe3_ff [3], fe3_in [3];
   logic signed [UNIT_W-1:0] side3_ff [3], fwd3_ff [3];
   coord_type                eye3_ff [3];
   logic signed [UPR_W-1:0]  upr4_ff [3], upr4_in [3];
   logic signed [DOT_W-1:0]  x0_4_ff, x0_4_in, x2_4_ff, x2_4_in;
   logic signed [UNIT_W-1:0] side4_ff [3], fwd4_ff [3];
   coord_type                eye4_ff [3];
   logic signed [DOT_W-1:0]  ue5_ff [3], ue5_in [3];
   logic signed [DOT_W-1:0]  x0_5_ff, x2_5_ff;
   logic signed [UNIT_W-1:0] side5_ff [3], fwd5_ff [3];
   logic signed [UPR_W-1:0]  upr5_ff [3];
   logic signed [DOT_W-1:0]  x1_6_ff, x1_6_in, x0_6_ff, x2_6_ff;
   logic signed [UNIT_W-1:0] side6_ff [3], fwd6_ff [3];
   logic signed [UPR_W-1:0]  upr6_ff [3];
   coord_type                rows7_ff [3][4], rows7_in [3][4];

   // Output holder: all four rows of one matrix, sent one per cycle while rsp_chan.ready is high.
   logic                     hold_valid_ff;
   row_type                  row_ff;
   coord_type                hold_ff [4][4];

   assign take = !hold_valid_ff || (rsp_chan.ready && row_ff == ROW_LAST);
   assign adv  = !t7_valid_ff || take;
   assign req_chan.ready = adv;

   always_comb begin
      fwd0_in[0] = FWD_W'(req_chan.target_x) - FWD_W'(req_chan.eye_x);
      fwd0_in[1] = FWD_W'(req_chan.target_y) - FWD_W'(req_chan.eye_y);
      fwd0_in[2] = FWD_W'(req_chan.target_z) - FWD_W'(req_chan.eye_z);
      sba_in = {req_chan.eye_x, req_chan.eye_y, req_chan.eye_z,
                req_chan.upvec_x, req_chan.upvec_y, req_chan.upvec_z};
   end

   lav_unit #(
      .IN_W      (FWD_W),
      .FRAC_BITS (FRAC_BITS),
      .SB_W      (SBA_W)
   ) u_fwd_unit (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (t0_valid_ff),
      .in_vec    (fwd0_ff),
      .in_sb     (sba_ff),
      .out_valid (a_valid),
      .out_vec   (a_vec),
      .out_sb    (a_sb)
   );

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         eye_a[i] = a_sb[SBA_W-1-i*COORD_W -: COORD_W];
         up_a[i]  = a_sb[3*COORD_W-1-i*COORD_W -: COORD_W];
      end
      // Cross product terms; component i is a[NXT]*b[PRV] - a[PRV]*b[NXT].
      for (int i = 0; i < 3; i++) begin
         p1a_in[i]   = PROD_W'(a_vec[NXT[i]]) * PROD_W'(up_a[PRV[i]]);
         p1b_in[i]   = PROD_W'(a_vec[PRV[i]]) * PROD_W'(up_a[NXT[i]]);
         side2_in[i] = p1a_ff[i] - p1b_ff[i];
      end
      sb1_in = {a_sb[SBA_W-1 -: 3*COORD_W], a_vec[0], a_vec[1], a_vec[2]};
   end

   lav_unit #(
      .IN_W      (PROD_W),
      .FRAC_BITS (FRAC_BITS),
      .SB_W      (SBB_W)
   ) u_side_unit (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (t2_valid_ff),
      .in_vec    (side2_ff),
      .in_sb     (sb2_ff),
      .out_valid (b_valid),
      .out_vec   (b_vec),
      .out_sb    (b_sb)
   );

   always_comb begin
      logic signed [UPP_W-1:0] upp;

      for (int i = 0; i < 3; i++) begin
         eye_b[i] = b_sb[SBB_W-1-i*COORD_W -: COORD_W];
         fwd_b[i] = b_sb[3*UNIT_W-1-i*UNIT_W -: UNIT_W];
      end

      // Up' = side x forward, and the row dot products with the eye.
      for (int i = 0; i < 3; i++) begin
         q3a_in[i] = UPP_W'(b_vec[NXT[i]]) * UPP_W'(fwd_b[PRV[i]]);
         q3b_in[i] = UPP_W'(b_vec[PRV[i]]) * UPP_W'(fwd_b[NXT[i]]);
         se3_in[i] = PROD_W'(b_vec[i]) * PROD_W'(eye_b[i]);
         fe3_in[i] = PROD_W'(fwd_b[i]) * PROD_W'(eye_b[i]);
      end

      // Round up' back to the fraction width, half up.
      for (int i = 0; i < 3; i++) begin
         upp = q3a_ff[i] - q3b_ff[i] + HALF_UPP;
         upr4_in[i] = UPR_W'(upp >>> FRAC_BITS);
      end
      // The back row is -forward, so its negated dot is the plain sum.
      x0_4_in = HALF_DOT - (DOT_W'(se3_ff[0]) + DOT_W'(se3_ff[1]) + DOT_W'(se3_ff[2]));
      x2_4_in = HALF_DOT + (DOT_W'(fe3_ff[0]) + DOT_W'(fe3_ff[1]) + DOT_W'(fe3_ff[2]));

      for (int i = 0; i < 3; i++) begin
         ue5_in[i] = DOT_W'(upr4_ff[i]) * DOT_W'(eye4_ff[i]);
      end
      x1_6_in = HALF_DOT - (ue5_ff[0] + ue5_ff[1] + ue5_ff[2]);

      for (int i = 0; i < 3; i++) begin
         rows7_in[0][i] = sat_fx(DOT_W'(side6_ff[i]));
         rows7_in[1][i] = sat_fx(DOT_W'(upr6_ff[i]));
         rows7_in[2][i] = sat_fx(-DOT_W'(fwd6_ff[i]));
      end
      rows7_in[0][3] = sat_fx(x0_6_ff >>> FRAC_BITS);
      rows7_in[1][3] = sat_fx(x1_6_ff >>> FRAC_BITS);
      rows7_in[2][3] = sat_fx(x2_6_ff >>> FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t0_valid_ff <= 1'b0;
         t1_valid_ff <= 1'b0;
         t2_valid_ff <= 1'b0;
         t3_valid_ff <= 1'b0;
         t4_valid_ff <= 1'b0;
         t5_valid_ff <= 1'b0;
         t6_valid_ff <= 1'b0;
         t7_valid_ff <= 1'b0;
      end else if (adv) begin
         t0_valid_ff <= req_chan.valid;
         t1_valid_ff <= a_valid;
         t2_valid_ff <= t1_valid_ff;
         t3_valid_ff <= b_valid;
         t4_valid_ff <= t3_valid_ff;
         t5_valid_ff <= t4_valid_ff;
         t6_valid_ff <= t5_valid_ff;
         t7_valid_ff <= t6_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fwd0_ff  <= fwd0_in;
         sba_ff   <= sba_in;
         p1a_ff   <= p1a_in;
         p1b_ff   <= p1b_in;
         sb1_ff   <= sb1_in;
         side2_ff <= side2_in;
         sb2_ff   <= sb1_ff;
         q3a_ff   <= q3a_in;
         q3b_ff   <= q3b_in;
         se3_ff   <= se3_in;
         fe3_ff   <= fe3_in;
         side3_ff <= b_vec;
         fwd3_ff  <= fwd_b;
         eye3_ff  <= eye_b;
         upr4_ff  <= upr4_in;
         x0_4_ff  <= x0_4_in;
         x2_4_ff  <= x2_4_in;
         side4_ff <= side3_ff;
         fwd4_ff  <= fwd3_ff;
         eye4_ff  <= eye3_ff;
         ue5_ff   <= ue5_in;
         x0_5_ff  <= x0_4_ff;
         x2_5_ff  <= x2_4_ff;
         side5_ff <= side4_ff;
         fwd5_ff  <= fwd4_ff;
         upr5_ff  <= upr4_ff;
         x1_6_ff  <= x1_6_in;
         x0_6_ff  <= x0_5_ff;
         x2_6_ff  <= x2_5_ff;
         side6_ff <= side5_ff;
         fwd6_ff  <= fwd5_ff;
         upr6_ff  <= upr5_ff;
         rows7_ff <= rows7_in;
      end
   end

   // The holder steps through its rows on each accepted response and is
   // refilled from the final stage when the last row leaves or while it is empty.
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         row_ff        <= ROW_SIDE;
      end else if (take) begin
         hold_valid_ff <= t7_valid_ff;
         row_ff        <= ROW_SIDE;
      end else if (rsp_chan.ready) begin
         row_ff <= row_ff + ROW_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (take && t7_valid_ff) begin
         hold_ff[ROW_SIDE] <= rows7_ff[ROW_SIDE];
         hold_ff[ROW_UP]   <= rows7_ff[ROW_UP];
         hold_ff[ROW_BACK] <= rows7_ff[ROW_BACK];
         hold_ff[ROW_LAST] <= '{coord_type'(0), coord_type'(0), coord_type'(0), ONE_FX};
      end
   end

   assign rsp_chan.valid     = hold_valid_ff;
   assign rsp_chan.row_index = row_ff;
   assign rsp_chan.entry_0   = hold_ff[row_ff][0];
   assign rsp_chan.entry_1   = hold_ff[row_ff][1];
   assign rsp_chan.entry_2   = hold_ff[row_ff][2];
   assign rsp_chan.entry_3   = hold_ff[row_ff][3];
   assign rsp_chan.last_row  = (row_ff == ROW_LAST);

   // An accepted request always lands in the first stage.
   assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> t0_valid_ff)
      else $error("accepted request did not enter the pipeline");

   // A finished matrix waiting for the holder is never dropped.
   assert property (@(posedge clock) disable iff (reset)
      t7_valid_ff && !adv |=> t7_valid_ff)
      else $error("final stage lost its matrix during a stall");

   // An empty holder always restarts at the first row.
   assert property (@(posedge clock) disable iff (reset)
      !hold_valid_ff |-> row_ff == ROW_SIDE)
      else $error("row counter not at the first row while the holder is empty");

endmodule
